// ===== rtl/core/nmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Normal map renormalizer package
// Shared widths, constants and pipeline payload types for the texel
// renormalization pipeline.
// ----------------------------------------------------------------------------
package nmr_pkg;

    // Channel and arithmetic widths.
    localparam int C_W    = 8;            // one color channel
    localparam int N_CH   = 3;            // red, green, blue
    localparam int D2_W   = 16;           // d*d, |d| <= 255
    localparam int S_W    = 18;           // sum of three squares
    localparam int RHS_W  = 32;           // 65025 * d*d
    localparam int T_W    = 34;           // 4 * m*m * S for m <= 127
    localparam int U_W    = 25;           // m * S for m <= 127
    localparam int M_W    = 7;            // quotient magnitude bits

    // Pipeline shape: two front stages, one stage per quotient bit, one output stage.
    localparam int N_STEP = M_W;
    localparam int N_STG  = N_STEP + 3;

    // Mid code of an unsigned channel.
    localparam logic [C_W-1:0] C_MID = 8'h80;

    typedef logic [C_W-1:0] t_chan;

    // One RGBA texel.
    typedef struct packed {
        t_chan [N_CH-1:0] c;
        t_chan            alpha;
    } t_texel;

    // Load strobes of the two front stages.
    typedef struct packed {
        logic ld0;
        logic ld1;
    } t_front_ctl;

    // Per-channel state of the quotient search.
    typedef struct packed {
        logic [M_W-1:0]   m;
        logic [T_W-1:0]   t;
        logic [U_W-1:0]   u;
        logic [RHS_W-1:0] rhs;
        logic             neg;
    } t_root;

    // Payload carried through the quotient search stages.
    typedef struct packed {
        t_root [N_CH-1:0] ch;
        logic [S_W-1:0]   s;
        t_texel           tex;
        logic             byp;
    } t_work;

endpackage

// ===== rtl/core/nmr_if.sv =====
// ----------------------------------------------------------------------------
// Texel stream interfaces
// Valid/ready channels for input texels and renormalized result texels.
// ----------------------------------------------------------------------------
interface nmr_in_if;
    logic                     valid;
    logic                     ready;
    logic [nmr_pkg::C_W-1:0]  red_in;
    logic [nmr_pkg::C_W-1:0]  green_in;
    logic [nmr_pkg::C_W-1:0]  blue_in;
    logic [nmr_pkg::C_W-1:0]  alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

interface nmr_out_if;
    logic                     valid;
    logic                     ready;
    logic [nmr_pkg::C_W-1:0]  red_out;
    logic [nmr_pkg::C_W-1:0]  green_out;
    logic [nmr_pkg::C_W-1:0]  blue_out;
    logic [nmr_pkg::C_W-1:0]  alpha_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, output ready);
endinterface

// ===== rtl/core/nmr_front.sv =====
// ----------------------------------------------------------------------------
// Renormalizer front end
// Two register stages: channel decode and squaring, then the sum of
// squares and the scaled right-hand side of the quotient test.
// ----------------------------------------------------------------------------
module nmr_front (
    input  logic                i_clk,
    input  nmr_pkg::t_front_ctl i_ctl,
    input  nmr_pkg::t_texel     i_tex,
    input  logic                i_byp,
    output nmr_pkg::t_work      o_work
);
    import nmr_pkg::*;

    t_texel                     r_tex;
    logic                       r_byp;
    logic [N_CH-1:0]            r_neg;
    logic [N_CH-1:0][D2_W-1:0]  r_d2;
    logic [N_CH-1:0][D2_W-1:0]  n_d2;
    logic [N_CH-1:0]            n_neg;
    logic [N_CH-1:0][C_W-1:0]   mag;
    t_work                      r_work;
    t_work                      n_work;

    // Stage 0 decode: |2c - 255| is the low seven bits (inverted below mid) with a one appended.
    always_comb begin
        for (int i = 0; i < N_CH; i++) begin
            n_neg[i] = !i_tex.c[i][C_W-1];
            mag[i]   = {(i_tex.c[i][C_W-1] ? i_tex.c[i][C_W-2:0] : ~i_tex.c[i][C_W-2:0]), 1'b1};
            n_d2[i]  = D2_W'(mag[i]) * D2_W'(mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld0) begin
            r_tex <= i_tex;
            r_byp <= i_byp;
            r_neg <= n_neg;
            r_d2  <= n_d2;
        end
    end

    // Stage 1: sum of squares and 65025 * d*d as (d*d << 16) - (d*d << 9) + d*d.
    always_comb begin
        n_work     = '0;
        n_work.s   = S_W'(r_d2[0]) + S_W'(r_d2[1]) + S_W'(r_d2[2]);
        n_work.tex = r_tex;
        n_work.byp = r_byp;
        for (int i = 0; i < N_CH; i++) begin
            n_work.ch[i].neg = r_neg[i];
            n_work.ch[i].rhs = (RHS_W'(r_d2[i]) << 16) - (RHS_W'(r_d2[i]) << 9)
                               + RHS_W'(r_d2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_work <= n_work;
        end
    end

    assign o_work = r_work;

endmodule

// ===== rtl/core/nmr_step.sv =====
// ----------------------------------------------------------------------------
// Quotient bit stage
// Decides one bit of floor(127.5*|d|/sqrt(S)) for all three channels by
// the exact test 4*m*m*S <= 65025*d*d, updated with shifts and adds.
// ----------------------------------------------------------------------------
module nmr_step #(
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_ld,
    input  nmr_pkg::t_work i_work,
    output nmr_pkg::t_work o_work
);
    import nmr_pkg::*;

    logic [N_CH-1:0][T_W-1:0] cand_t;
    logic [N_CH-1:0][U_W-1:0] cand_u;
    t_work                    n_work;
    t_work                    r_work;

    // Trial m' = m + 2^BIT: 4m'^2S = 4m^2S + 2^(BIT+3)*mS + 2^(2BIT+2)*S, and m'S = mS + 2^BIT*S.
    always_comb begin
        n_work = i_work;
        for (int i = 0; i < N_CH; i++) begin
            cand_t[i] = i_work.ch[i].t + (T_W'(i_work.ch[i].u) << (BIT + 3))
                        + (T_W'(i_work.s) << (2 * BIT + 2));
            cand_u[i] = i_work.ch[i].u + (U_W'(i_work.s) << BIT);
            if (cand_t[i] <= T_W'(i_work.ch[i].rhs)) begin
                n_work.ch[i].m = i_work.ch[i].m | (M_W'(1) << BIT);
                n_work.ch[i].t = cand_t[i];
                n_work.ch[i].u = cand_u[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_work <= n_work;
        end
    end

    assign o_work = r_work;

endmodule

// ===== rtl/core/nmr_back.sv =====
// ----------------------------------------------------------------------------
// Renormalizer output stage
// Forms the signed result around the mid code, or passes the texel
// through in bypass, into the output register.
// ----------------------------------------------------------------------------
module nmr_back (
    input  logic            i_clk,
    input  logic            i_ld,
    input  nmr_pkg::t_work  i_work,
    output nmr_pkg::t_texel o_tex
);
    import nmr_pkg::*;

    logic [N_CH-1:0] exact;
    t_texel          n_tex;
    t_texel          r_tex;

    // Positive channels take 128 + floor(q); negative ones 128 - ceil(q).
    always_comb begin
        n_tex.alpha = i_work.tex.alpha;
        for (int i = 0; i < N_CH; i++) begin
            exact[i] = (i_work.ch[i].t == T_W'(i_work.ch[i].rhs));
            if (i_work.byp) begin
                n_tex.c[i] = i_work.tex.c[i];
            end else if (i_work.ch[i].neg) begin
                n_tex.c[i] = C_MID - C_W'(i_work.ch[i].m) - C_W'(!exact[i]);
            end else begin
                n_tex.c[i] = C_MID + C_W'(i_work.ch[i].m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_tex <= n_tex;
        end
    end

    assign o_tex = r_tex;

endmodule

// ===== rtl/core/normal_map_texel_renormalize.sv =====
// Throughput: one texel per cycle while the output is not stalled; the quotient search takes one stage per bit.
// Each stage holds its item only while the stage after it is full and stalled.
// Reset (synchronous, active low) empties the pipeline and sets renorm_enable to 1.
// ----------------------------------------------------------------------------
// Normal map texel renormalizer
// Renormalizes the RGB vector of an RGBA8 normal map texel with an exact
// shift-and-add quotient search, or passes it through when renorm_enable is 0; alpha passes unchanged.
// ----------------------------------------------------------------------------
module normal_map_texel_renormalize (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    nmr_in_if.sink     i_texel,
    nmr_out_if.source  o_texel
);
    import nmr_pkg::*;

    logic                r_renorm_en;
    logic [N_STG-1:0]    r_vld;
    logic [N_STG-1:0]    n_vld;
    logic [N_STG-1:0]    go;
    logic [N_STG-1:0]    vld_in;
    t_texel              in_tex;
    t_texel              out_tex;
    t_front_ctl          front_ctl;
    t_work               w_work [N_STEP+1];

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_renorm_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_renorm_en <= i_cfg_wdata;
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        go[N_STG-1] = !r_vld[N_STG-1] || o_texel.ready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            go[k] = !r_vld[k] || go[k+1];
        end
        vld_in = {r_vld[N_STG-2:0], i_texel.valid};
        n_vld  = (go & vld_in) | (~go & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_texel.ready = go[0];

    // Input texel into the front end.
    assign in_tex.c[0]  = i_texel.red_in;
    assign in_tex.c[1]  = i_texel.green_in;
    assign in_tex.c[2]  = i_texel.blue_in;
    assign in_tex.alpha = i_texel.alpha_in;
    assign front_ctl.ld0 = go[0];
    assign front_ctl.ld1 = go[1];

    nmr_front u_front (
        .i_clk  (i_clk),
        .i_ctl  (front_ctl),
        .i_tex  (in_tex),
        .i_byp  (!r_renorm_en),
        .o_work (w_work[0])
    );

    // One stage per quotient bit, most significant first.
    for (genvar j = 0; j < N_STEP; j++) begin : g_step
        nmr_step #(
            .BIT (M_W - 1 - j)
        ) u_step (
            .i_clk  (i_clk),
            .i_ld   (go[2+j]),
            .i_work (w_work[j]),
            .o_work (w_work[j+1])
        );
    end

    nmr_back u_back (
        .i_clk  (i_clk),
        .i_ld   (go[N_STG-1]),
        .i_work (w_work[N_STEP]),
        .o_tex  (out_tex)
    );

    // Output transaction.
    assign o_texel.valid     = r_vld[N_STG-1];
    assign o_texel.red_out   = out_tex.c[0];
    assign o_texel.green_out = out_tex.c[1];
    assign o_texel.blue_out  = out_tex.c[2];
    assign o_texel.alpha_out = out_tex.alpha;

`ifndef SYNTHESIS
    // A sum of three odd squares is always 3 modulo 8.
    a_sum_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (w_work[0].s[2:0] == 3'd3))
        else $error("sum of squares has wrong residue");

    // The accepted quotient never overshoots the scaled right-hand side.
    a_t_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[N_STG-2] |->
            (w_work[N_STEP].ch[0].t <= T_W'(w_work[N_STEP].ch[0].rhs)) &&
            (w_work[N_STEP].ch[1].t <= T_W'(w_work[N_STEP].ch[1].rhs)) &&
            (w_work[N_STEP].ch[2].t <= T_W'(w_work[N_STEP].ch[2].rhs)))
        else $error("quotient test overshoots");

    // The running product tracks m times the sum of squares.
    a_u_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[N_STG-2] |->
            (w_work[N_STEP].ch[0].u == U_W'(w_work[N_STEP].ch[0].m) * U_W'(w_work[N_STEP].s)) &&
            (w_work[N_STEP].ch[1].u == U_W'(w_work[N_STEP].ch[1].m) * U_W'(w_work[N_STEP].s)) &&
            (w_work[N_STEP].ch[2].u == U_W'(w_work[N_STEP].ch[2].m) * U_W'(w_work[N_STEP].s)))
        else $error("running product out of step");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Normal map texel renormalizer testbench
// Drives RGBA8 texels through the valid/ready input channel and checks every
// output transaction against an exact integer model of the renormalization.
// Both sides idle at random. The receiver also holds off for long stretches,
// and the run alternates between renormalize and pass-through settings.
// ----------------------------------------------------------------------------
module tb_top;

    import nmr_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int LATENCY      = 10;
    localparam int STALL_CYCLES = 60;
    localparam int IDLE_PCT     = 19;
    localparam int CYCLE_LIMIT  = 400000;
    localparam longint unsigned UNIT_SCALE_SQ = 65025;  // 255 * 255

    // One texel with its channels named.
    typedef struct {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha;
    } t_rgba;

    // Scoreboard: predicts each accepted texel and matches results in order.
    class texel_scoreboard;
        t_rgba expected_texels[$];
        bit    renorm_on = 1'b1;
        int    mismatch_count;
        int    renorm_count;
        int    bypass_count;

        function int pending_count();
            return expected_texels.size();
        endfunction

        // Exact floor(127.5 * d / sqrt(s) + 128) by an integer search on m.
        function automatic t_chan renormalized_channel(int d, longint unsigned s_sum);
            longint unsigned mag;
            longint unsigned rhs;
            longint unsigned m_fit;
            int              level;
            bit              exact;
            mag   = longint'((d < 0) ? -d : d);
            rhs   = UNIT_SCALE_SQ * mag * mag;
            m_fit = 0;
            for (longint unsigned m = 1; m <= 128; m++) begin
                if (4 * m * m * s_sum <= rhs)
                    m_fit = m;
            end
            exact = (4 * m_fit * m_fit * s_sum == rhs);
            if (d >= 0)
                level = int'(C_MID) + int'(m_fit);
            else
                level = int'(C_MID) - int'(exact ? m_fit : m_fit + 1);
            if (level < 0)
                level = 0;
            if (level > 255)
                level = 255;
            return t_chan'(level);
        endfunction

        // Work out the result of one accepted input transaction.
        function void note_texel(t_rgba t);
            t_rgba           want;
            int              dr, dg, db;
            longint unsigned s_sum;
            want = t;
            if (renorm_on) begin
                dr    = 2 * int'(t.red) - 255;
                dg    = 2 * int'(t.green) - 255;
                db    = 2 * int'(t.blue) - 255;
                s_sum = longint'(dr * dr + dg * dg + db * db);
                if (s_sum == 0) begin
                    want.red   = C_MID;
                    want.green = C_MID;
                    want.blue  = C_MID;
                end else begin
                    want.red   = renormalized_channel(dr, s_sum);
                    want.green = renormalized_channel(dg, s_sum);
                    want.blue  = renormalized_channel(db, s_sum);
                end
                renorm_count++;
            end else begin
                bypass_count++;
            end
            expected_texels.push_back(want);
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < 40)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        // Compare one output transaction with the oldest expectation.
        task check_texel(t_rgba got);
            t_rgba want;
            if (expected_texels.size() == 0) begin
                report_mismatch($sformatf("result %0h %0h %0h %0h with nothing expected",
                                          got.red, got.green, got.blue, got.alpha));
            end else begin
                want = expected_texels.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
                if (got.alpha !== want.alpha)
                    report_mismatch($sformatf("alpha %0d, want %0d", got.alpha, want.alpha));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    nmr_in_if  texel_in();
    nmr_out_if texel_out();

    normal_map_texel_renormalize DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_texel     (texel_in),
        .o_texel     (texel_out)
    );

    texel_scoreboard sb = new();

    bit          no_idle;
    int          stall_requests;
    int          drain_pauses;
    int unsigned cycle_count;

    // Axis vectors, shortest vectors, corners and mixed signs.
    t_rgba edge_texels[16] = '{
        '{8'd255, 8'd128, 8'd128, 8'd255}, '{8'd0,   8'd128, 8'd128, 8'd0},
        '{8'd128, 8'd255, 8'd128, 8'h5A},  '{8'd128, 8'd0,   8'd128, 8'hA5},
        '{8'd128, 8'd128, 8'd255, 8'd1},   '{8'd128, 8'd128, 8'd0,   8'd254},
        '{8'd127, 8'd127, 8'd127, 8'h80},  '{8'd128, 8'd128, 8'd128, 8'h7F},
        '{8'd127, 8'd128, 8'd128, 8'd0},   '{8'd255, 8'd255, 8'd255, 8'd255},
        '{8'd0,   8'd0,   8'd0,   8'd0},   '{8'd255, 8'd0,   8'd255, 8'h3C},
        '{8'd0,   8'd255, 8'd0,   8'hC3},  '{8'd128, 8'd127, 8'd255, 8'h11},
        '{8'd255, 8'd254, 8'd1,   8'hEE},  '{8'd1,   8'd2,   8'd253, 8'h44}
    };

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Watch both channels for transactions.
    always @(posedge i_clk) begin
        t_rgba got;
        t_rgba sent;
        if (i_rst_n) begin
            if (texel_out.valid && texel_out.ready) begin
                got = '{texel_out.red_out, texel_out.green_out,
                        texel_out.blue_out, texel_out.alpha_out};
                sb.check_texel(got);
            end
            if (texel_in.valid && texel_in.ready) begin
                sent = '{texel_in.red_in, texel_in.green_in,
                         texel_in.blue_in, texel_in.alpha_in};
                sb.note_texel(sent);
            end
        end
    end

    // Output receiver: random idling, plus long hold-offs on request.
    initial begin
        int stalls_served;
        int hold_left;
        stalls_served   = 0;
        hold_left       = 0;
        texel_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stalls_served != stall_requests) begin
                stalls_served++;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                texel_out.ready <= 1'b0;
            end else begin
                texel_out.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Random texel, biased toward corners and short vectors now and then.
    function automatic t_rgba make_texel();
        t_chan corners[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        t_rgba t;
        int    mode;
        mode    = $urandom_range(9);
        t.red   = t_chan'($urandom_range(255));
        t.green = t_chan'($urandom_range(255));
        t.blue  = t_chan'($urandom_range(255));
        t.alpha = t_chan'($urandom_range(255));
        if (mode == 5 || mode == 6) begin
            t.red   = corners[3'($urandom_range(5))];
            t.green = corners[3'($urandom_range(5))];
            t.blue  = corners[3'($urandom_range(5))];
        end else if (mode == 7 || mode == 8) begin
            t.red   = t_chan'($urandom_range(135, 120));
            t.green = t_chan'($urandom_range(135, 120));
            t.blue  = t_chan'($urandom_range(135, 120));
        end else if (mode == 9) begin
            t.red   = t_chan'($urandom_range(128, 127));
            t.green = t_chan'($urandom_range(128, 127));
        end
        return t;
    endfunction

    // Offer one texel; starts and ends at a falling edge, valid left as is.
    task automatic send_texel(t_rgba t);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            texel_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        texel_in.valid    <= 1'b1;
        texel_in.red_in   <= t.red;
        texel_in.green_in <= t.green;
        texel_in.blue_in  <= t.blue;
        texel_in.alpha_in <= t.alpha;
        do @(posedge i_clk); while (!texel_in.ready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        texel_in.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_count() != 0);
    endtask

    // Register write while the pipeline is empty.
    task automatic write_renorm_enable(bit value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.renorm_on = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random texels with an optional output hold-off, drain pause and calm stretch.
    task automatic run_random(int count, int stall_at, int pause_at, int calm_lo,
                              int calm_hi);
        for (int i = 0; i < count; i++) begin
            if (i == stall_at)
                stall_requests++;
            if (i == pause_at) begin
                drain_results();
                drain_pauses++;
            end
            no_idle = (i >= calm_lo) && (i < calm_hi);
            send_texel(make_texel());
        end
        no_idle = 1'b0;
    endtask

    // Main sequence.
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        texel_in.valid    = 1'b0;
        texel_in.red_in   = '0;
        texel_in.green_in = '0;
        texel_in.blue_in  = '0;
        texel_in.alpha_in = '0;
        no_idle           = 1'b0;
        stall_requests    = 0;
        drain_pauses      = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texels, renormalized.
        write_renorm_enable(1'b1);
        foreach (edge_texels[i])
            send_texel(edge_texels[i]);

        // A few of them again in pass-through.
        drain_results();
        write_renorm_enable(1'b0);
        for (int i = 0; i < 8; i++)
            send_texel(edge_texels[i]);

        // Random phases across both settings.
        drain_results();
        write_renorm_enable(1'b1);
        run_random(500, 100, 250, 300, 450);

        drain_results();
        write_renorm_enable(1'b0);
        run_random(300, 50, -1, -1, -1);

        drain_results();
        write_renorm_enable(1'b1);
        run_random(500, 400, 200, -1, -1);

        // Let the pipeline settle, then report.
        drain_results();
        repeat (LATENCY + 5) @(negedge i_clk);

        $display("Covered %0d texels: %0d renormalized and %0d passed through.",
                 sb.renorm_count + sb.bypass_count, sb.renorm_count, sb.bypass_count);
        $display("Output held off %0d times, input paused for a full drain %0d times.",
                 stall_requests, drain_pauses);
        if (sb.mismatch_count == 0 && sb.pending_count() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
